### hw/rtl/linked_list_remove_neighbor_sum_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the neighbour-sum linked list block
// Clocked on clk, held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LINKED_LIST_REMOVE_NEIGHBOR_SUM_MACROS_SVH
`define LINKED_LIST_REMOVE_NEIGHBOR_SUM_MACROS_SVH

// Same-cycle implication
`define LLRNS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("llrns check failed");

// Next-cycle implication
`define LLRNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("llrns check failed");

`endif

### hw/rtl/llrns_pkg.sv
// ---------------------------------------------------------------------------
// llrns_pkg
// Types and codes shared by the neighbour-sum linked list block.
// ---------------------------------------------------------------------------
package llrns_pkg;

  localparam int VAL_W = 12;
  localparam int CFG_W = 11;
  localparam int SUM_W = 23;
  localparam int STAT_W = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_REMOVED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BEYOND  = 2'd3;

  typedef struct packed {
    logic             op;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              left_present;
    logic [VAL_W-1:0]  left_value;
    logic              right_present;
    logic [VAL_W-1:0]  right_value;
    logic [SUM_W-1:0]  running_sum;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_LOOK,
    S_LINK,
    S_VAL
  } state_t;

  typedef struct packed {
    logic              clr_wr;
    logic              capture;
    logic              load_wr;
    logic              node_rd;
    logic              splice;
    logic              res_code;
    logic [STAT_W-1:0] code;
    logic              res_remove;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic beyond;
    logic hit;
    logic removed;
  } dp_stat_t;

endpackage

### hw/rtl/llrns_ctrl.sv
// ---------------------------------------------------------------------------
// llrns_ctrl
// Sequencer: clearing pass, then one item at a time through the memory reads.
// ---------------------------------------------------------------------------
module llrns_ctrl
  import llrns_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_op,
  input  dp_stat_t   stat,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_op == OP_REMOVE) ? S_LOOK : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.res_code = 1'b1;
        if (stat.beyond) begin
          cmd.code = STAT_BEYOND;
        end else begin
          cmd.load_wr = 1'b1;
          cmd.code    = STAT_OK;
        end
        state_nxt = S_IDLE;
      end
      S_LOOK: begin
        if (!stat.hit) begin
          cmd.res_code = 1'b1;
          cmd.code     = STAT_UNKNOWN;
          state_nxt    = S_IDLE;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_LINK;
        end
      end
      S_LINK: begin
        if (stat.removed) begin
          cmd.res_code = 1'b1;
          cmd.code     = STAT_REMOVED;
          state_nxt    = S_IDLE;
        end else begin
          cmd.splice = 1'b1;
          state_nxt  = S_VAL;
        end
      end
      S_VAL: begin
        cmd.res_remove = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/llrns_dp.sv
// ---------------------------------------------------------------------------
// llrns_dp
// Node, link, mark and value-map memories, counters, sum and result register.
// ---------------------------------------------------------------------------
module llrns_dp
  import llrns_pkg::*;
#(
  parameter int MAX_NODES   = 1024,
  parameter int VALUE_SPACE = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  output logic             out_valid,
  output out_item_t        out_data
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int VW   = $clog2(VALUE_SPACE);
  localparam int CNTW = NW + 1;
  // link and map entries: {valid, node index}
  localparam int LW   = NW + 1;

  logic [VAL_W-1:0] nv_mem [MAX_NODES];
  logic [LW-1:0]    ll_mem [MAX_NODES];
  logic [LW-1:0]    rl_mem [MAX_NODES];
  logic             rm_mem [MAX_NODES];
  logic [LW-1:0]    map_mem [VALUE_SPACE];

  logic [CFG_W-1:0]  node_cnt_r;
  logic [CNTW-1:0]   loaded_cnt_r;
  logic [SUM_W-1:0]  total_r;
  logic [VW-1:0]     clr_cnt_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [VAL_W-1:0]  value_r;
  logic              in_space_r;
  logic [LW-1:0]     map_q_r;
  logic [LW-1:0]     ll_q_r;
  logic [LW-1:0]     rl_q_r;
  logic              rm_q_r;
  logic [VAL_W-1:0]  nv_l_q_r;
  logic [VAL_W-1:0]  nv_r_q_r;

  logic [31:0]       limit;
  logic [31:0]       cnt_ext;
  logic              last_node;
  logic [NW-1:0]     idx;
  logic [LW-1:0]     load_left;
  logic [LW-1:0]     load_right;
  logic [VW-1:0]     map_wr_addr;
  logic [VW-1:0]     map_rd_addr;
  logic [NW-1:0]     x_idx;
  logic [NW-1:0]     l_idx;
  logic [NW-1:0]     r_idx;
  logic [VAL_W-1:0]  lv;
  logic [VAL_W-1:0]  rv;
  logic [SUM_W:0]    sum_raw;
  logic [SUM_W-1:0]  sum_sat;

  // effective count is the register capped at the node store depth
  assign limit = (32'(node_cnt_r) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(node_cnt_r);
  assign cnt_ext   = 32'(loaded_cnt_r);
  assign last_node = (cnt_ext + 32'd1) >= limit;
  assign idx       = loaded_cnt_r[NW-1:0];
  assign load_left  = (loaded_cnt_r == '0) ? '0 : {1'b1, idx - NW'(1)};
  assign load_right = last_node ? '0 : {1'b1, idx + NW'(1)};

  assign map_wr_addr = VW'(value_r);
  assign map_rd_addr = VW'(in_data.value);
  assign x_idx = map_q_r[NW-1:0];
  assign l_idx = ll_q_r[NW-1:0];
  assign r_idx = rl_q_r[NW-1:0];

  assign stat.clr_last = (clr_cnt_r == VW'(VALUE_SPACE - 1));
  assign stat.beyond   = cnt_ext >= limit;
  assign stat.hit      = in_space_r & map_q_r[NW];
  assign stat.removed  = rm_q_r;

  assign lv      = ll_q_r[NW] ? nv_l_q_r : '0;
  assign rv      = rl_q_r[NW] ? nv_r_q_r : '0;
  assign sum_raw = (SUM_W+1)'(total_r) + (SUM_W+1)'(lv) + (SUM_W+1)'(rv);
  assign sum_sat = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];

  // value map: clearing pass, load writes, lookup on capture
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      map_mem[clr_cnt_r] <= '0;
    end else if (cmd.load_wr && in_space_r) begin
      map_mem[map_wr_addr] <= {1'b1, idx};
    end
    if (cmd.capture) begin
      map_q_r <= map_mem[map_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      nv_mem[idx] <= value_r;
    end
    if (cmd.splice) begin
      nv_l_q_r <= nv_mem[l_idx];
      nv_r_q_r <= nv_mem[r_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      ll_mem[idx] <= load_left;
    end else if (cmd.splice && rl_q_r[NW]) begin
      ll_mem[r_idx] <= ll_q_r;
    end
    if (cmd.node_rd) begin
      ll_q_r <= ll_mem[x_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      rl_mem[idx] <= load_right;
    end else if (cmd.splice && ll_q_r[NW]) begin
      rl_mem[l_idx] <= rl_q_r;
    end
    if (cmd.node_rd) begin
      rl_q_r <= rl_mem[x_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      rm_mem[idx] <= 1'b0;
    end else if (cmd.splice) begin
      rm_mem[x_idx] <= 1'b1;
    end
    if (cmd.node_rd) begin
      rm_q_r <= rm_mem[x_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r   <= CFG_W'(1);
      loaded_cnt_r <= '0;
      total_r      <= '0;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_code | cmd.res_remove;
      if (cfg_we) begin
        node_cnt_r <= cfg_wdata;
      end
      if (cmd.load_wr) begin
        loaded_cnt_r <= loaded_cnt_r + CNTW'(1);
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + VW'(1);
      end
      if (cmd.res_remove) begin
        total_r <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_r    <= in_data.value;
      in_space_r <= (32'(in_data.value) < 32'(VALUE_SPACE));
    end
    if (cmd.res_code) begin
      out_data_r.status        <= cmd.code;
      out_data_r.left_present  <= 1'b0;
      out_data_r.left_value    <= '0;
      out_data_r.right_present <= 1'b0;
      out_data_r.right_value   <= '0;
      out_data_r.running_sum   <= total_r;
    end else if (cmd.res_remove) begin
      out_data_r.status        <= STAT_OK;
      out_data_r.left_present  <= ll_q_r[NW];
      out_data_r.left_value    <= lv;
      out_data_r.right_present <= rl_q_r[NW];
      out_data_r.right_value   <= rv;
      out_data_r.running_sum   <= sum_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/linked_list_remove_neighbor_sum.sv
// ---------------------------------------------------------------------------
// linked_list_remove_neighbor_sum
// Array-backed doubly linked list: loads append nodes, removes splice a node
// out and report and sum the values of its neighbours.
// ---------------------------------------------------------------------------
//  channel   ports                       transfer at rising edge when
//  input     start, busy, in_data        start high and busy low
//  result    out_valid, out_data         out_valid high (one cycle only)
//  config    cfg_we, cfg_wdata           cfg_we high (node count)
//
// A load is checked and written and its result registered; a remove steps
// through the value map read, link and mark reads, the two neighbour value
// reads alongside the link write-back, then the sum. An unknown value ends after
// the map read, an already removed one after the link and mark reads. After
// reset busy stays high while the value map is swept clear, one entry a
// cycle; configuration writes are taken meanwhile. Results are never held.
// ---------------------------------------------------------------------------
module linked_list_remove_neighbor_sum
  import llrns_pkg::*;
#(
  parameter int MAX_NODES   = 1024,
  parameter int VALUE_SPACE = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: drives one command set per cycle from the current state
  llrns_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_data.op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // memories, counters, the running sum and the result register
  llrns_dp #(
    .MAX_NODES   (MAX_NODES),
    .VALUE_SPACE (VALUE_SPACE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/llrns_chk.sv
// ---------------------------------------------------------------------------
// llrns_chk
// Port-level checks on the neighbour-sum linked list block, bound to the top.
// ---------------------------------------------------------------------------
`include "linked_list_remove_neighbor_sum_macros.svh"

module llrns_chk
  import llrns_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  `LLRNS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid)
  `LLRNS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `LLRNS_ASSERT_SAME(a_result_idle, out_valid, !busy)
  `LLRNS_ASSERT_SAME(a_error_no_neighbours, out_valid && (out_data.status != STAT_OK),
                     !out_data.left_present && !out_data.right_present &&
                     (out_data.left_value == '0) && (out_data.right_value == '0))

endmodule

bind linked_list_remove_neighbor_sum llrns_chk u_llrns_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
